// File: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Holds the request and status codes and the control word that the top level
// broadcasts to every storage cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

	localparam int unsigned DATA_W = 32;

	// Request codes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Empty-pop answer
	localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = '1;

	// Command broadcast to all cells, active only for an accepted word
	typedef struct packed {
		logic              shift_right;  // push front: every entry moves one cell back
		logic              shift_left;   // pop front: every entry moves one cell forward
		logic              back_fill;    // first free cell takes the value
		logic              back_drop;    // last live cell drops its entry
		logic [DATA_W-1:0] push_value;
	} ctrl_t;

endpackage

`default_nettype wire

// File: rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue chain
// Holds one entry and its live flag. Cell 0 is the front of the queue; live
// cells always form an unbroken run starting at cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dq_pkg::ctrl_t             ctrl,
	input  wire logic [dq_pkg::DATA_W-1:0] left_data,
	input  wire logic                      left_valid,
	input  wire logic [dq_pkg::DATA_W-1:0] right_data,
	input  wire logic                      right_valid,
	output logic      [dq_pkg::DATA_W-1:0] data,
	output logic                           valid,
	output logic                           is_back
);

	logic [dq_pkg::DATA_W-1:0] data_q;
	logic                      valid_q;

	// Live flag: moves with the chain, set on a back push, cleared on a back pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift_right) begin
			valid_q <= left_valid;
		end else if (ctrl.shift_left) begin
			valid_q <= right_valid;
		end else if (ctrl.back_fill && !valid_q && left_valid) begin
			valid_q <= 1'b1;
		end else if (ctrl.back_drop && valid_q && !right_valid) begin
			valid_q <= 1'b0;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.shift_right) begin
			data_q <= left_data;
		end else if (ctrl.shift_left) begin
			data_q <= right_data;
		end else if (ctrl.back_fill && !valid_q && left_valid) begin
			data_q <= ctrl.push_value;
		end
	end

	assign data    = data_q;
	assign valid   = valid_q;
	assign is_back = valid_q && !right_valid;

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit words in a chain of cells
// Input channel (in_valid/in_stall) carries one request word: op and
// push_value. Output channel (out_valid/out_stall) returns one result word
// per request: read_value, status and is_empty after the request.
// Requests: push front, push back, pop front, pop back, peek front, peek
// back. A pop on an empty queue answers -1, a peek on an empty queue 0, both
// with status empty; a push into a full queue is dropped with status full.
// The result is registered in the output register when the request is accepted.
// Throughput: one request per cycle unless the receiver stalls. The front entry always sits in cell 0;
// the back entry is picked from the cell whose live flag is the last one
// set, an AND-OR selection across all DEPTH cells that sets the cycle time.
// When the receiver stalls, the result is held in the output register and
// in_stall rises, so no further request is taken until the result leaves;
// a result taken in the same cycle frees the way for the next request.
// Reset (arst_n low) empties the queue and clears out_valid; no clearing
// pass is needed, the block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         op,
	input  wire logic signed [31:0] push_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      read_value,
	output logic [1:0]              status,
	output logic                    is_empty
);

	localparam int unsigned W = dq_pkg::DATA_W;

	logic [W-1:0]  cell_data  [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] cell_back;

	dq_pkg::ctrl_t ctrl;
	logic          accept;
	logic          empty_now;
	logic          full_now;
	logic [W-1:0]  front_value;
	logic [W-1:0]  back_value;

	logic [W-1:0]  rd_next;
	logic [1:0]    st_next;
	logic          empty_next;

	logic          out_valid_q;
	logic [W-1:0]  read_value_q;
	logic [1:0]    status_q;
	logic          is_empty_q;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = out_valid_q && out_stall;
	assign empty_now = !cell_valid[0];
	assign full_now  = cell_valid[DEPTH-1];

	// Cell chain: cell 0 sees the incoming word on its left, the last cell an
	// empty neighbor on its right
	for (genvar i = 0; i < DEPTH; i++) begin : g_chain
		logic [W-1:0] l_data;
		logic         l_valid;
		logic [W-1:0] r_data;
		logic         r_valid;

		if (i == 0) begin : g_first
			assign l_data  = push_value;
			assign l_valid = 1'b1;
		end else begin : g_inner_l
			assign l_data  = cell_data[i-1];
			assign l_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner_r
			assign r_data  = cell_data[i+1];
			assign r_valid = cell_valid[i+1];
		end

		dq_cell u_slot (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (r_valid),
			.data        (cell_data[i]),
			.valid       (cell_valid[i]),
			.is_back     (cell_back[i])
		);
	end

	// Front and back words
	assign front_value = cell_data[0];

	always_comb begin
		back_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_value = back_value | (cell_data[i] & {W{cell_back[i]}});
		end
	end

	// Request decode and result
	always_comb begin
		ctrl             = '0;
		ctrl.push_value  = push_value;
		rd_next          = '0;
		st_next          = dq_pkg::ST_DONE;
		empty_next       = empty_now;
		case (op)
			dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
				if (full_now) begin
					st_next = dq_pkg::ST_FULL;
				end else begin
					ctrl.shift_right = accept && (op == dq_pkg::OP_PUSH_FRONT);
					ctrl.back_fill   = accept && (op == dq_pkg::OP_PUSH_BACK);
					empty_next       = 1'b0;
				end
			end
			dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
				if (empty_now) begin
					rd_next = dq_pkg::POP_EMPTY_VALUE;
					st_next = dq_pkg::ST_EMPTY;
				end else begin
					rd_next         = (op == dq_pkg::OP_POP_FRONT) ? front_value : back_value;
					ctrl.shift_left = accept && (op == dq_pkg::OP_POP_FRONT);
					ctrl.back_drop  = accept && (op == dq_pkg::OP_POP_BACK);
					empty_next      = !cell_valid[1];
				end
			end
			dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK: begin
				if (empty_now) begin
					st_next = dq_pkg::ST_EMPTY;
				end else begin
					rd_next = (op == dq_pkg::OP_PEEK_FRONT) ? front_value : back_value;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_next;
			status_q     <= st_next;
			is_empty_q   <= empty_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign is_empty   = is_empty_q;

endmodule

`default_nettype wire

// File: rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches the channels of the top level and flags results that break the
// handshake or disagree with the request that caused them.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [2:0]         op,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] read_value,
	input wire logic [1:0]         status,
	input wire logic               is_empty
);

	// A stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
		else $error("stalled result word changed");

	// Every accepted request shows a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted request gave no result");

	// Pops and peeks never report a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == dq_pkg::OP_POP_FRONT || op == dq_pkg::OP_POP_BACK
			|| op == dq_pkg::OP_PEEK_FRONT || op == dq_pkg::OP_PEEK_BACK)
		|=> status != dq_pkg::ST_FULL)
		else $error("full status on a read request");

	// A dropped push answers zero and leaves a non-empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dq_pkg::ST_FULL |-> read_value == 32'sd0 && !is_empty)
		else $error("bad result for a dropped push");

	// An empty status means the queue is still empty
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dq_pkg::ST_EMPTY |-> is_empty)
		else $error("empty status with a non-empty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.op         (op),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_value (read_value),
	.status     (status),
	.is_empty   (is_empty)
);

`default_nettype wire

// File: bench/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the double-ended queue
// A driver feeds request words from a backlog and a monitor checks every
// result word against a ring model of the deque updated at request accept.
// Runs a directed opener, then biased fill/drain bursts under four
// idle/stall mixes.
// ----------------------------------------------------------------------------

module double_ended_queue_tb;

	localparam int unsigned DQ_DEPTH  = 16;
	localparam int unsigned CYCLE_CAP = 100000;
	localparam int          RAND_REQS = 205;

	// Op codes the block treats as no-ops
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [2:0]         code;
		logic signed [31:0] value;
	} deque_req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic               empty_after;
	} deque_result_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [2:0]         op         = dq_pkg::OP_PUSH_FRONT;
	logic signed [31:0] push_value = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic               is_empty;

	deque_req_t    req_backlog[$];
	deque_result_t awaited[$];
	int            idle_pct   = 0;
	int            stall_pct  = 0;
	int            mismatches = 0;
	int unsigned   cycle_cnt  = 0;

	// Deque model: ring with head slot and live count (DQ_DEPTH is a power of two)
	logic signed [31:0] ring [DQ_DEPTH];
	logic [3:0]         head_slot = '0;
	logic [4:0]         live_cnt  = '0;

	double_ended_queue #(.DEPTH(DQ_DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.status     (status),
		.is_empty   (is_empty)
	);

	always #1 clk = ~clk;

	// Apply one request to the ring model and return the result it should give
	function automatic deque_result_t deque_update(input logic [2:0] code,
			input logic signed [31:0] value);
		deque_result_t res;
		logic [3:0]    tail_slot;
		res = '0;
		res.status = dq_pkg::ST_DONE;
		tail_slot = head_slot + 4'(live_cnt - 5'd1);
		case (code)
		dq_pkg::OP_PUSH_FRONT: begin
			if (live_cnt == DQ_DEPTH) begin
				res.status = dq_pkg::ST_FULL;
			end else begin
				head_slot = head_slot - 4'd1;
				ring[head_slot] = value;
				live_cnt = live_cnt + 5'd1;
			end
		end
		dq_pkg::OP_PUSH_BACK: begin
			if (live_cnt == DQ_DEPTH) begin
				res.status = dq_pkg::ST_FULL;
			end else begin
				ring[head_slot + live_cnt[3:0]] = value;
				live_cnt = live_cnt + 5'd1;
			end
		end
		dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
			if (live_cnt == 0) begin
				res.value = dq_pkg::POP_EMPTY_VALUE;
				res.status = dq_pkg::ST_EMPTY;
			end else if (code == dq_pkg::OP_POP_FRONT) begin
				res.value = ring[head_slot];
				head_slot = head_slot + 4'd1;
				live_cnt = live_cnt - 5'd1;
			end else begin
				res.value = ring[tail_slot];
				live_cnt = live_cnt - 5'd1;
			end
		end
		dq_pkg::OP_PEEK_FRONT: begin
			if (live_cnt == 0)
				res.status = dq_pkg::ST_EMPTY;
			else
				res.value = ring[head_slot];
		end
		dq_pkg::OP_PEEK_BACK: begin
			if (live_cnt == 0)
				res.status = dq_pkg::ST_EMPTY;
			else
				res.value = ring[tail_slot];
		end
		default: ;
		endcase
		res.empty_after = (live_cnt == 0);
		return res;
	endfunction

	// Driver: predict on accept, then present the next word or go idle
	always @(posedge clk) begin : driver
		deque_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				awaited.insert(awaited.size(), deque_update(op, push_value));
			if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = req_backlog[0];
				req_backlog.delete(0);
				in_valid   <= 1'b1;
				op         <= nxt.code;
				push_value <= nxt.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result word, then pick next stall
	always @(posedge clk) begin : monitor
		deque_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				$error("result word with no request outstanding");
				mismatches++;
			end else begin
				want = awaited[0];
				awaited.delete(0);
				if (read_value !== want.value) begin
					$error("read_value: expected %0d, got %0d", want.value, read_value);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (is_empty !== want.empty_after) begin
					$error("is_empty: expected %0d, got %0d", want.empty_after, is_empty);
					mismatches++;
				end
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_req(input logic [2:0] code, input logic signed [31:0] value);
		deque_req_t r;
		r.code  = code;
		r.value = value;
		req_backlog.insert(req_backlog.size(), r);
	endtask

	// Mostly random bits, with the signed extremes, -1 and 0 mixed in
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
		0: return 32'sh8000_0000;
		1: return 32'sh7fff_ffff;
		2: return -32'sd1;
		3: return 32'sd0;
		default: return $urandom;
		endcase
	endfunction

	// Bursts biased toward filling, draining or mixed, so full and empty are hit
	task automatic queue_random(input int count);
		int         left;
		int         burst;
		int         push_pct;
		int         roll;
		logic [2:0] code;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(24, 4);
			case ($urandom_range(2))
			0: push_pct = 85;
			1: push_pct = 15;
			default: push_pct = 50;
			endcase
			for (int i = 0; i < burst && left > 0; i++) begin
				roll = $urandom_range(99);
				if (roll < 5) begin
					code = $urandom_range(1) ? OP_UNUSED_LO : OP_UNUSED_HI;
				end else if ($urandom_range(99) < push_pct) begin
					code = $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
				end else begin
					case ($urandom_range(3))
					0: code = dq_pkg::OP_POP_FRONT;
					1: code = dq_pkg::OP_POP_BACK;
					2: code = dq_pkg::OP_PEEK_FRONT;
					default: code = dq_pkg::OP_PEEK_BACK;
					endcase
				end
				queue_req(code, pick_value());
				left--;
			end
		end
	endtask

	task automatic run_phase(input int idle, input int stall);
		idle_pct  = idle;
		stall_pct = stall;
		queue_random(RAND_REQS);
		while (req_backlog.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: pops, peeks and the unused codes on an empty deque
		queue_req(dq_pkg::OP_POP_FRONT, 32'sd5);
		queue_req(dq_pkg::OP_POP_BACK, -32'sd7);
		queue_req(dq_pkg::OP_PEEK_FRONT, 32'sd0);
		queue_req(dq_pkg::OP_PEEK_BACK, 32'sh7fff_ffff);
		queue_req(OP_UNUSED_LO, 32'sh8000_0000);
		queue_req(OP_UNUSED_HI, -32'sd1);
		// Extreme values through both ends
		queue_req(dq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
		queue_req(dq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
		queue_req(dq_pkg::OP_PEEK_FRONT, 32'sd0);
		queue_req(dq_pkg::OP_PEEK_BACK, 32'sd0);
		queue_req(dq_pkg::OP_POP_BACK, 32'sd0);
		queue_req(dq_pkg::OP_POP_FRONT, 32'sd0);
		// Fill to capacity from both ends, then a dropped push
		for (int i = 0; i < DQ_DEPTH; i++)
			queue_req(i[0] ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
				i < 2 ? -32'sd1 : pick_value());
		queue_req(dq_pkg::OP_PUSH_BACK, 32'sh5a5a_a5a5);

		run_phase(0, 0);
		run_phase(71, 0);
		run_phase(0, 71);
		run_phase(11, 11);

		while (in_valid || awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
